### design/pwblc_pkg.sv
// ----------------------------------------------------------------------------
// pwblc_pkg
// Shared types and codes for the page wear bitmap cache.
// ----------------------------------------------------------------------------
package pwblc_pkg;

  localparam int PAGE_W   = 30;
  localparam int WEAR_W   = 32;
  localparam int STATUS_W = 3;
  localparam int WORD_W   = 64;

  localparam logic [1:0] OP_FILL    = 2'd0;
  localparam logic [1:0] OP_PREPARE = 2'd1;
  localparam logic [1:0] OP_PUT     = 2'd2;

  localparam logic [STATUS_W-1:0] ST_NEW_PAGE = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SWAP_ALL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd4;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [PAGE_W-1:0] page;
    logic [WEAR_W-1:0] wear_count;
  } pwblc_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   new_page;
  } pwblc_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_FMOD,
    S_COPY,
    S_SCAN,
    S_UMOD,
    S_DONE
  } pwblc_state_t;

endpackage

### design/pwblc_ram.sv
// ----------------------------------------------------------------------------
// pwblc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pwblc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/page_wear_bitmap_lru_cache_core.sv
// ----------------------------------------------------------------------------
// page_wear_bitmap_lru_cache_core
// LRU cache of per-block page bitmaps for wear-aware page replacement.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) takes one transaction at a time:
// a wear fill, a swap prepare or a swap put. Every transaction yields exactly
// one result on the output channel (out_valid/out_ready/out_data).
// Group tags, valid bits and LRU ranks sit in flops and are searched
// combinationally; page maps live in one RAM of GROUPS*(PAGES_PER_BLOCK/64) 64-bit words
// and the map under fill in a second RAM, both with registered read data.
// A fill updates one bit of the fill RAM; the last fill of a block also copies
// its W = PAGES_PER_BLOCK/64 words into the page-map RAM word by word. A prepare
// hit passes over the page-map words one by one; a put hit clears one bit; misses go straight to the result.
// The next transaction is accepted once the result is in the output register,
// so a held result does not block the input; if the receiver still stalls
// the previous result, the finished one waits in its final state.
// Reset (rst_n low, synchronous) clears valid bits, ranks, the group count
// and the threshold; RAM contents need no clearing since a map word is only
// read after its group has been filled. cfg_we writes wear_threshold.
// ----------------------------------------------------------------------------
module page_wear_bitmap_lru_cache_core
  import pwblc_pkg::*;
#(
  parameter int GROUPS          = 8,
  parameter int PAGES_PER_BLOCK = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pwblc_in_t         in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pwblc_out_t        out_data,
  input  logic              cfg_we,
  input  logic [WEAR_W-1:0] cfg_wdata
);

  localparam int IW  = $clog2(PAGES_PER_BLOCK);
  localparam int MW  = PAGES_PER_BLOCK / WORD_W;
  localparam int WW  = (IW > 6) ? IW - 6 : 1;
  localparam int TW  = PAGE_W - IW;
  localparam int SW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int CW  = $clog2(GROUPS + 1);
  localparam int PD  = GROUPS * MW;
  localparam int PAW = (PD > 1) ? $clog2(PD) : 1;
  localparam int FAW = (MW > 1) ? $clog2(MW) : 1;

  pwblc_state_t state_r, state_nxt;

  logic [WEAR_W-1:0] thr_r;
  pwblc_in_t         item_r;
  logic [TW-1:0]     tag_r [GROUPS];
  logic              vld_r [GROUPS];
  logic [SW-1:0]     rank_r [GROUPS];
  logic [CW-1:0]     gcnt_r;
  logic [SW-1:0]     slot_r;
  logic [WW:0]       cnt_r;
  logic              found_r;
  logic [IW-1:0]     fidx_r;
  pwblc_out_t        res_r;
  logic              out_valid_r;
  pwblc_out_t        out_data_r;

  logic [IW-1:0]     idx;
  logic [WW-1:0]     ow;
  logic [WORD_W-1:0] bitm;
  logic [TW-1:0]     blk;
  logic              last_fill;

  assign idx       = item_r.page[IW-1:0];
  assign ow        = WW'(idx >> 6);
  assign bitm      = WORD_W'(1) << idx[5:0];
  assign blk       = item_r.page[PAGE_W-1:IW];
  assign last_fill = (idx == IW'(PAGES_PER_BLOCK - 1));

  function automatic logic [PAW-1:0] paddr(input logic [SW-1:0] s, input logic [WW-1:0] w);
    paddr = PAW'(int'(s) * MW + int'(w));
  endfunction

  // tag search, free slot and least-recent slot
  logic          hit;
  logic [SW-1:0] hit_s;
  logic          free_ok;
  logic [SW-1:0] free_s;
  logic [SW-1:0] old_s;

  always_comb begin
    hit     = 1'b0;
    hit_s   = '0;
    free_ok = 1'b0;
    free_s  = '0;
    old_s   = '0;
    for (int i = GROUPS - 1; i >= 0; i--) begin
      if (vld_r[i] && tag_r[i] == blk) begin
        hit   = 1'b1;
        hit_s = SW'(i);
      end
      if (!vld_r[i]) begin
        free_ok = 1'b1;
        free_s  = SW'(i);
      end
    end
    for (int i = 1; i < GROUPS; i++) begin
      if (rank_r[i] > rank_r[old_s]) begin
        old_s = SW'(i);
      end
    end
  end

  // install target and promotion
  logic          ins_new;
  logic [SW-1:0] ins_s;
  logic [CW-1:0] ins_old;
  logic          pen;
  logic [SW-1:0] ps;
  logic [CW-1:0] po;

  always_comb begin
    ins_new = 1'b0;
    if (hit) begin
      ins_s   = hit_s;
      ins_old = CW'(rank_r[hit_s]);
    end else if (free_ok) begin
      ins_s   = free_s;
      ins_old = gcnt_r;
      ins_new = 1'b1;
    end else begin
      ins_s   = old_s;
      ins_old = CW'(rank_r[old_s]);
    end
    pen = 1'b0;
    ps  = hit_s;
    po  = CW'(rank_r[hit_s]);
    if (state_r == S_LOOK && item_r.opcode == OP_PREPARE && hit) begin
      pen = 1'b1;
    end else if (state_r == S_FMOD && last_fill) begin
      pen = 1'b1;
      ps  = ins_s;
      po  = ins_old;
    end
  end

  // memories
  logic              pm_we;
  logic [PAW-1:0]    pm_waddr;
  logic [WORD_W-1:0] pm_wdata;
  logic [PAW-1:0]    pm_raddr;
  logic [WORD_W-1:0] pm_rdata;
  logic              fm_we;
  logic [FAW-1:0]    fm_waddr;
  logic [WORD_W-1:0] fm_wdata;
  logic [FAW-1:0]    fm_raddr;
  logic [WORD_W-1:0] fm_rdata;

  pwblc_ram #(.WIDTH(WORD_W), .DEPTH(PD)) u_page_ram (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (pm_wdata),
    .raddr (pm_raddr),
    .rdata (pm_rdata)
  );

  pwblc_ram #(.WIDTH(WORD_W), .DEPTH(MW)) u_fill_ram (
    .clk   (clk),
    .we    (fm_we),
    .waddr (fm_waddr),
    .wdata (fm_wdata),
    .raddr (fm_raddr),
    .rdata (fm_rdata)
  );

  // scan datapath: word cnt-1 is on the read data
  logic [WW-1:0]     wi;
  logic [WORD_W-1:0] sm;
  logic [5:0]        fz;
  logic              take;
  logic [WORD_W-1:0] sm_wr;

  always_comb begin
    wi = WW'(cnt_r - 1'b1);
    sm = pm_rdata | ((wi == ow) ? bitm : '0);
    fz = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!sm[b]) begin
        fz = 6'(b);
      end
    end
    take  = !found_r && !(&sm);
    sm_wr = take ? (sm | (WORD_W'(1) << fz)) : sm;
  end

  logic done_ld;
  assign done_ld  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        case (item_r.opcode)
          OP_FILL:    state_nxt = S_FMOD;
          OP_PREPARE: state_nxt = hit ? S_SCAN : S_DONE;
          OP_PUT:     state_nxt = hit ? S_UMOD : S_DONE;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_FMOD:  state_nxt = last_fill ? S_COPY : S_DONE;
      S_COPY:  state_nxt = (cnt_r == (WW+1)'(MW)) ? S_DONE : S_COPY;
      S_SCAN:  state_nxt = (cnt_r == (WW+1)'(MW)) ? S_DONE : S_SCAN;
      S_UMOD:  state_nxt = S_DONE;
      S_DONE:  state_nxt = done_ld ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    pm_we    = 1'b0;
    pm_waddr = paddr(slot_r, wi);
    pm_wdata = sm_wr;
    pm_raddr = paddr(slot_r, WW'(cnt_r));
    fm_we    = 1'b0;
    fm_waddr = FAW'(ow);
    fm_wdata = (item_r.wear_count > thr_r) ? (fm_rdata | bitm) : (fm_rdata & ~bitm);
    fm_raddr = FAW'(ow);
    case (state_r)
      S_LOOK: begin
        pm_raddr = (item_r.opcode == OP_PUT) ? paddr(hit_s, ow) : paddr(hit_s, '0);
      end
      S_FMOD: begin
        fm_we = 1'b1;
      end
      S_COPY: begin
        fm_raddr = FAW'(cnt_r);
        pm_we    = (cnt_r != '0);
        pm_wdata = fm_rdata;
      end
      S_SCAN: begin
        pm_we = 1'b1;
      end
      S_UMOD: begin
        pm_we    = 1'b1;
        pm_waddr = paddr(slot_r, ow);
        pm_wdata = pm_rdata & ~bitm;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= '0;
      gcnt_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < GROUPS; i++) begin
        vld_r[i]  <= 1'b0;
        rank_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (done_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (pen) begin
        for (int i = 0; i < GROUPS; i++) begin
          if (SW'(i) == ps) begin
            rank_r[i] <= '0;
          end else if (vld_r[i] && CW'(rank_r[i]) < po) begin
            rank_r[i] <= rank_r[i] + 1'b1;
          end
        end
      end
      if (state_r == S_FMOD && last_fill && ins_new) begin
        vld_r[ins_s] <= 1'b1;
        gcnt_r       <= gcnt_r + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (done_ld) begin
      out_data_r <= res_r;
    end
    case (state_r)
      S_LOOK: begin
        slot_r  <= hit_s;
        cnt_r   <= (WW+1)'(1);
        found_r <= 1'b0;
        res_r   <= '{status: ((item_r.opcode == OP_PREPARE && !hit) ? ST_MISS : ST_IGNORED),
                     new_page: '0};
      end
      S_FMOD: begin
        res_r.status <= ST_DONE;
        cnt_r        <= '0;
        if (last_fill) begin
          slot_r        <= ins_s;
          tag_r[ins_s]  <= blk;
        end
      end
      S_COPY: begin
        cnt_r <= cnt_r + 1'b1;
      end
      S_SCAN: begin
        cnt_r <= cnt_r + 1'b1;
        if (take) begin
          found_r <= 1'b1;
          fidx_r  <= IW'({wi, fz});
        end
        if (cnt_r == (WW+1)'(MW)) begin
          if (found_r || take) begin
            res_r.status   <= ST_NEW_PAGE;
            res_r.new_page <= {blk, (take ? IW'({wi, fz}) : fidx_r)};
          end else begin
            res_r.status <= ST_SWAP_ALL;
          end
        end
      end
      S_UMOD: begin
        res_r.status <= ST_DONE;
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic [CW-1:0] vld_cnt;
  always_comb begin
    vld_cnt = '0;
    for (int i = 0; i < GROUPS; i++) begin
      vld_cnt = vld_cnt + CW'(vld_r[i]);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    gcnt_r <= CW'(GROUPS))
    else $error("group count above capacity");

  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    vld_cnt == gcnt_r)
    else $error("group count disagrees with valid slots");

  a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_LOOK))
    else $error("accepted transaction did not start a lookup");

  a_pm_write: assert property (@(posedge clk) disable iff (!rst_n)
    pm_we |-> (state_r == S_SCAN || state_r == S_COPY || state_r == S_UMOD))
    else $error("page map written outside an update pass");

endmodule
